@@ rtl/core/fbs_pkg.sv @@
// Package for the FASTA record base statistics block.
// Holds the character codes, scale constants, controller states and the
// command and status structs shared by the controller and the datapath.
package fbs_pkg;

    // Character codes of the file text.
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_HEADER  = 8'h3E;
    localparam logic [7:0] CHAR_CASE    = 8'h20;
    localparam logic [7:0] CHAR_LO      = 8'h41;
    localparam logic [7:0] CHAR_HI      = 8'h7A;
    localparam logic [7:0] CHAR_A_LC    = 8'h61;
    localparam logic [7:0] CHAR_C_LC    = 8'h63;
    localparam logic [7:0] CHAR_G_LC    = 8'h67;
    localparam logic [7:0] CHAR_T_LC    = 8'h74;

    // Base lane indexes.
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    // Fixed-point scales.
    localparam int unsigned GC_SCALE    = 10000;
    localparam int unsigned RATIO_SCALE = 1000;
    localparam int unsigned CODON_SIZE  = 3;

    // Output field widths.
    localparam int unsigned OUT_COUNT_W = 32;
    localparam int unsigned OUT_CODON_W = 31;
    localparam int unsigned OUT_GC_W    = 14;
    localparam int unsigned OUT_TM_W    = 34;
    localparam int unsigned OUT_RATIO_W = 32;

    typedef enum logic [1:0] {
        DIV_GC,
        DIV_RATIO
    } t_div_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_GC_GO,
        ST_GC_WAIT,
        ST_RAT_GO,
        ST_RAT_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic    count_en;
        logic    clear_rec;
        logic    snap;
        logic    prep;
        logic    div_start;
        logic    capture;
        logic    load_out;
        t_div_op div_sel;
    } t_cmd;

    typedef struct packed {
        logic is_nl;
        logic is_gt;
        logic is_base;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

@@ rtl/core/fasta_record_base_statistics.sv @@
// Top level of the FASTA record base statistics block.
// Joins fbs_ctrl and fbs_datapath; depends on fbs_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | i_valid / o_stall  | i_data_byte, i_end_of_file
//  out     | output    | o_valid / i_stall  | counts, codons, GC, Tm, ratio, flags
//
// One file word is taken every cycle while o_stall is low, and the codon count runs
// alongside the base counters. When a record closes, its counts are copied aside and
// two serial divisions (GC, then ratio) run on one shared divider; the result is then
// loaded into the output register as soon as that register is free.
// Counting of the next record carries on meanwhile; only a word that would
// close another record is stalled until the previous result has been loaded.
// Reset is synchronous and needs no clearing pass.
module fasta_record_base_statistics #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_end_of_file,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_a,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_c,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_g,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_t,
    output logic [fbs_pkg::OUT_CODON_W-1:0]      o_codon_count,
    output logic [fbs_pkg::OUT_GC_W-1:0]         o_gc_hundredths_percent,
    output logic [fbs_pkg::OUT_TM_W-1:0]         o_melt_temp,
    output logic [fbs_pkg::OUT_RATIO_W-1:0]      o_ratio_thousandths,
    output logic                                 o_ratio_undefined,
    output logic                                 o_no_valid_bases,
    output logic                                 o_count_saturated
);
    import fbs_pkg::*;

    t_cmd    cmd;
    t_status sts;

    fbs_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_end_of_file (i_end_of_file),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_stall       (o_stall)
    );

    fbs_datapath #(
        .CW (COUNT_WIDTH)
    ) u_datapath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_data_byte             (i_data_byte),
        .i_cmd                   (cmd),
        .o_sts                   (sts),
        .i_stall                 (i_stall),
        .o_valid                 (o_valid),
        .o_count_a               (o_count_a),
        .o_count_c               (o_count_c),
        .o_count_g               (o_count_g),
        .o_count_t               (o_count_t),
        .o_codon_count           (o_codon_count),
        .o_gc_hundredths_percent (o_gc_hundredths_percent),
        .o_melt_temp             (o_melt_temp),
        .o_ratio_thousandths     (o_ratio_thousandths),
        .o_ratio_undefined       (o_ratio_undefined),
        .o_no_valid_bases        (o_no_valid_bases),
        .o_count_saturated       (o_count_saturated)
    );

endmodule

@@ rtl/core/fbs_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Stand-alone; used by the FASTA statistics datapath.
module fbs_divider #(
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);
    localparam int CNTW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_dvs;
    logic [CNTW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH:0]   diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_q[WIDTH-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = rem_sh >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[WIDTH-2:0], ge};
            r_rem <= ge ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ rtl/core/fbs_ctrl.sv @@
// Controller of the FASTA statistics block: line parser state and the
// record-end sequencer. Depends on fbs_pkg.
module fbs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_end_of_file,
    input  fbs_pkg::t_status i_sts,
    output fbs_pkg::t_cmd   o_cmd,
    output logic            o_stall
);
    import fbs_pkg::*;

    t_state r_state, n_state;
    logic   r_als, n_als;
    logic   r_hdr, n_hdr;
    logic   r_has, n_has;

    logic   acc;
    logic   gt_open;
    logic   close_gt;
    logic   has_after;
    logic   would_close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_als   <= 1'b1;
            r_hdr   <= 1'b0;
            r_has   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_als   <= n_als;
            r_hdr   <= n_hdr;
            r_has   <= n_has;
        end
    end

    always_comb begin
        gt_open  = r_als & i_sts.is_gt;
        close_gt = gt_open & r_has;
        if (i_sts.is_nl) begin
            has_after = r_has;
        end else if (gt_open) begin
            has_after = 1'b0;
        end else begin
            has_after = r_hdr ? r_has : 1'b1;
        end
        would_close = close_gt | (i_end_of_file & has_after);
        // A closing word waits only while the previous record is still in work.
        o_stall = (r_state != ST_IDLE) & would_close;
        acc     = i_valid & ~o_stall;

        n_als = r_als;
        n_hdr = r_hdr;
        n_has = r_has;
        o_cmd = '0;
        o_cmd.div_sel = DIV_GC;

        if (acc) begin
            if (i_sts.is_nl) begin
                n_als = 1'b1;
                n_hdr = 1'b0;
            end else if (gt_open) begin
                n_als = 1'b0;
                n_hdr = 1'b1;
                n_has = 1'b0;
            end else begin
                n_als = 1'b0;
                n_has = has_after;
                o_cmd.count_en = ~r_hdr & i_sts.is_base;
            end
            if (i_end_of_file) begin
                n_als = 1'b1;
                n_hdr = 1'b0;
                n_has = 1'b0;
            end
            o_cmd.snap      = would_close;
            o_cmd.clear_rec = gt_open | i_end_of_file;
        end

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.snap) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_GC_GO;
            end
            ST_GC_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_GC;
                n_state         = ST_GC_WAIT;
            end
            ST_GC_WAIT: begin
                o_cmd.div_sel = DIV_GC;
                if (i_sts.div_done) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_RAT_GO;
                end
            end
            ST_RAT_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RATIO;
                n_state         = ST_RAT_WAIT;
            end
            ST_RAT_WAIT: begin
                o_cmd.div_sel = DIV_RATIO;
                if (i_sts.div_done) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/fbs_datapath.sv @@
// Datapath of the FASTA statistics block: byte classifier, base counters,
// record snapshot, shared divider and output register. Depends on fbs_pkg.
module fbs_datapath #(
    parameter int CW = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [7:0]                           i_data_byte,
    input  fbs_pkg::t_cmd                        i_cmd,
    output fbs_pkg::t_status                     o_sts,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_a,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_c,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_g,
    output logic [fbs_pkg::OUT_COUNT_W-1:0]      o_count_t,
    output logic [fbs_pkg::OUT_CODON_W-1:0]      o_codon_count,
    output logic [fbs_pkg::OUT_GC_W-1:0]         o_gc_hundredths_percent,
    output logic [fbs_pkg::OUT_TM_W-1:0]         o_melt_temp,
    output logic [fbs_pkg::OUT_RATIO_W-1:0]      o_ratio_thousandths,
    output logic                                 o_ratio_undefined,
    output logic                                 o_no_valid_bases,
    output logic                                 o_count_saturated
);
    import fbs_pkg::*;

    localparam int SW = CW + 2;                       // four-count sum
    localparam int PW = CW + 1;                       // two-count sum
    localparam int DW = CW + 17;                      // divider width
    localparam int TW = (CW + 5 > 35) ? CW + 5 : 35;  // melting temperature
    localparam int MW = (CW > 32) ? CW : 32;          // count output extension
    localparam int CXW = (SW > 32) ? SW : 32;         // codon output extension
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    // Byte classifier.
    logic [7:0] b_low;
    logic [1:0] base_idx;
    logic       is_base;

    always_comb begin
        b_low    = i_data_byte | CHAR_CASE;
        base_idx = BASE_A;
        is_base  = 1'b0;
        if (i_data_byte >= CHAR_LO && i_data_byte <= CHAR_HI) begin
            if (b_low == CHAR_A_LC) begin
                base_idx = BASE_A;
                is_base  = 1'b1;
            end else if (b_low == CHAR_C_LC) begin
                base_idx = BASE_C;
                is_base  = 1'b1;
            end else if (b_low == CHAR_G_LC) begin
                base_idx = BASE_G;
                is_base  = 1'b1;
            end else if (b_low == CHAR_T_LC) begin
                base_idx = BASE_T;
                is_base  = 1'b1;
            end
        end
    end

    // Saturating base counters.
    logic [CW-1:0] r_cnt [4];
    logic [CW-1:0] n_cnt [4];
    logic          r_sat, n_sat;
    // The codon count runs with the counters; the phase counts bases modulo three.
    logic [SW-1:0] r_cod, n_cod;
    logic [1:0]    r_cod_ph, n_cod_ph;
    logic          base_inc;

    always_comb begin
        n_sat    = r_sat;
        base_inc = 1'b0;
        for (int k = 0; k < 4; k++) begin
            n_cnt[k] = r_cnt[k];
            if (i_cmd.count_en && base_idx == 2'(k)) begin
                if (r_cnt[k] != CMAX) begin
                    n_cnt[k] = r_cnt[k] + 1'b1;
                    base_inc = 1'b1;
                end
                if (n_cnt[k] == CMAX) begin
                    n_sat = 1'b1;
                end
            end
        end
        n_cod    = r_cod;
        n_cod_ph = r_cod_ph;
        if (base_inc) begin
            if (r_cod_ph == 2'(CODON_SIZE - 1)) begin
                n_cod_ph = '0;
                n_cod    = r_cod + 1'b1;
            end else begin
                n_cod_ph = r_cod_ph + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
            r_sat    <= 1'b0;
            r_cod    <= '0;
            r_cod_ph <= '0;
        end else if (i_cmd.clear_rec) begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
            r_sat    <= 1'b0;
            r_cod    <= '0;
            r_cod_ph <= '0;
        end else begin
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
            r_sat    <= n_sat;
            r_cod    <= n_cod;
            r_cod_ph <= n_cod_ph;
        end
    end

    // Snapshot of the closed record, including the closing word's base.
    logic [CW-1:0] r_snap [4];
    logic          r_snap_sat;
    logic [SW-1:0] r_snap_cod;
    logic [SW-1:0] r_total;
    logic [PW-1:0] r_gc;
    logic [PW-1:0] r_pur;
    logic [PW-1:0] r_pyr;
    logic [PW-1:0] r_at;

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            for (int k = 0; k < 4; k++) begin
                r_snap[k] <= n_cnt[k];
            end
            r_snap_sat <= n_sat;
            r_snap_cod <= n_cod;
        end
        if (i_cmd.prep) begin
            r_gc    <= PW'(r_snap[BASE_G]) + PW'(r_snap[BASE_C]);
            r_at    <= PW'(r_snap[BASE_A]) + PW'(r_snap[BASE_T]);
            r_pur   <= PW'(r_snap[BASE_A]) + PW'(r_snap[BASE_G]);
            r_pyr   <= PW'(r_snap[BASE_C]) + PW'(r_snap[BASE_T]);
            r_total <= SW'(r_snap[BASE_A]) + SW'(r_snap[BASE_C])
                     + SW'(r_snap[BASE_G]) + SW'(r_snap[BASE_T]);
        end
    end

    // Shared divider; each quotient is rounded by adding half the divisor.
    logic [DW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [DW-1:0] div_q;
    logic          div_done;

    always_comb begin
        case (i_cmd.div_sel)
            DIV_GC: begin
                div_num = DW'(r_gc) * DW'(GC_SCALE) + DW'(r_total >> 1);
                div_den = DW'(r_total);
            end
            DIV_RATIO: begin
                div_num = DW'(r_pur) * DW'(RATIO_SCALE) + DW'(r_pyr >> 1);
                div_den = DW'(r_pyr);
            end
            default: begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    fbs_divider #(
        .WIDTH (DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    logic [OUT_GC_W-1:0]    r_gcp;
    logic [OUT_RATIO_W-1:0] r_ratio;
    logic                   total_zero;
    logic                   pyr_zero;

    assign total_zero = (r_total == '0);
    assign pyr_zero   = (r_pyr == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            case (i_cmd.div_sel)
                DIV_GC: begin
                    r_gcp <= total_zero ? '0 : div_q[OUT_GC_W-1:0];
                end
                DIV_RATIO: begin
                    if (pyr_zero) begin
                        r_ratio <= '0;
                    end else if (|div_q[DW-1:OUT_RATIO_W]) begin
                        r_ratio <= '1;
                    end else begin
                        r_ratio <= div_q[OUT_RATIO_W-1:0];
                    end
                end
                default: begin
                    r_gcp <= r_gcp;
                end
            endcase
        end
    end

    // Melting temperature, codon count and the extended counts for the output word.
    logic [TW-1:0]          tm_full;
    logic [OUT_TM_W-1:0]    tm_sat;
    logic [MW-1:0]          ext_cnt [4];
    logic [CXW-1:0]         cod_ext;
    logic [OUT_CODON_W-1:0] codon_sat;

    always_comb begin
        tm_full = (TW'(r_at) << 1) + (TW'(r_gc) << 2);
        tm_sat  = (|tm_full[TW-1:OUT_TM_W]) ? '1 : tm_full[OUT_TM_W-1:0];
        for (int k = 0; k < 4; k++) begin
            ext_cnt[k] = MW'(r_snap[k]);
        end
        cod_ext   = CXW'(r_snap_cod);
        codon_sat = (|cod_ext[CXW-1:OUT_CODON_W]) ? '1 : cod_ext[OUT_CODON_W-1:0];
    end

    // Output register.
    logic r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_count_a               <= ext_cnt[BASE_A][OUT_COUNT_W-1:0];
            o_count_c               <= ext_cnt[BASE_C][OUT_COUNT_W-1:0];
            o_count_g               <= ext_cnt[BASE_G][OUT_COUNT_W-1:0];
            o_count_t               <= ext_cnt[BASE_T][OUT_COUNT_W-1:0];
            o_codon_count           <= codon_sat;
            o_gc_hundredths_percent <= r_gcp;
            o_melt_temp             <= tm_sat;
            o_ratio_thousandths     <= r_ratio;
            o_ratio_undefined       <= pyr_zero;
            o_no_valid_bases        <= total_zero;
            o_count_saturated       <= r_snap_sat;
        end
    end

    assign o_valid = r_ov;

    always_comb begin
        o_sts          = '0;
        o_sts.is_nl    = (i_data_byte == CHAR_NEWLINE);
        o_sts.is_gt    = (i_data_byte == CHAR_HEADER);
        o_sts.is_base  = is_base;
        o_sts.div_done = div_done;
        o_sts.out_free = ~r_ov | ~i_stall;
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for fasta_record_base_statistics.
// Streams FASTA text words into the block, predicts each record's statistics
// and checks every result word; depends on fbs_pkg and the block's RTL only.
`timescale 1ns / 100ps

module testbench;
    import fbs_pkg::*;

    // The block is built with its narrowest counters, away from the default width.
    localparam int          CNT_W        = 16;
    localparam logic [63:0] CNT_MAX      = (64'd1 << CNT_W) - 64'd1;
    localparam logic [63:0] CODON_MAX    = (64'd1 << OUT_CODON_W) - 64'd1;
    localparam logic [63:0] TM_MAX       = (64'd1 << OUT_TM_W) - 64'd1;
    localparam logic [63:0] RATIO_MAX    = (64'd1 << OUT_RATIO_W) - 64'd1;
    localparam logic [7:0]  CHAR_CR      = 8'h0D;
    localparam int          CYCLE_LIMIT  = 600_000;
    localparam int          SETTLE_WAIT  = 2 * (2 * CNT_W + 40);
    localparam int          PRINT_LIMIT  = 40;

    typedef struct {
        logic [7:0] data;
        logic       eof;
    } t_file_word;

    typedef struct {
        logic [OUT_COUNT_W-1:0] count_a;
        logic [OUT_COUNT_W-1:0] count_c;
        logic [OUT_COUNT_W-1:0] count_g;
        logic [OUT_COUNT_W-1:0] count_t;
        logic [OUT_CODON_W-1:0] codon_count;
        logic [OUT_GC_W-1:0]    gc_hundredths;
        logic [OUT_TM_W-1:0]    melt_temp;
        logic [OUT_RATIO_W-1:0] ratio_thousandths;
        logic                   ratio_undefined;
        logic                   no_valid_bases;
        logic                   count_saturated;
    } t_record_stats;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_valid       = 1'b0;
    logic [7:0]             i_data_byte   = 8'h00;
    logic                   i_end_of_file = 1'b0;
    logic                   i_stall       = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [OUT_COUNT_W-1:0] o_count_a;
    logic [OUT_COUNT_W-1:0] o_count_c;
    logic [OUT_COUNT_W-1:0] o_count_g;
    logic [OUT_COUNT_W-1:0] o_count_t;
    logic [OUT_CODON_W-1:0] o_codon_count;
    logic [OUT_GC_W-1:0]    o_gc_hundredths_percent;
    logic [OUT_TM_W-1:0]    o_melt_temp;
    logic [OUT_RATIO_W-1:0] o_ratio_thousandths;
    logic                   o_ratio_undefined;
    logic                   o_no_valid_bases;
    logic                   o_count_saturated;

    // Words waiting to be sent, the file being built, and predicted results.
    t_file_word    text_q[$];
    t_file_word    file_buf[$];
    t_record_stats pending_stats[$];

    // Predictor state.
    logic        line_start    = 1'b1;
    logic        in_header     = 1'b0;
    logic        rec_has_chars = 1'b0;
    logic [63:0] base_cnt [4]  = '{default: 64'd0};
    logic        sat_seen      = 1'b0;

    int  send_idle       = 0;
    int  recv_idle       = 0;
    int  calm_left       = 0;
    int  cycle_count     = 0;
    int  words_queued    = 0;
    int  words_taken     = 0;
    int  files_queued    = 0;
    int  records_checked = 0;
    int  fail_count      = 0;
    int  target;
    logic word_fire      = 1'b0;

    fasta_record_base_statistics #(
        .COUNT_WIDTH(CNT_W)
    ) DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_stall                (o_stall),
        .i_data_byte            (i_data_byte),
        .i_end_of_file          (i_end_of_file),
        .o_valid                (o_valid),
        .i_stall                (i_stall),
        .o_count_a              (o_count_a),
        .o_count_c              (o_count_c),
        .o_count_g              (o_count_g),
        .o_count_t              (o_count_t),
        .o_codon_count          (o_codon_count),
        .o_gc_hundredths_percent(o_gc_hundredths_percent),
        .o_melt_temp            (o_melt_temp),
        .o_ratio_thousandths    (o_ratio_thousandths),
        .o_ratio_undefined      (o_ratio_undefined),
        .o_no_valid_bases       (o_no_valid_bases),
        .o_count_saturated      (o_count_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int lane_of(logic [7:0] b);
        logic [7:0] lc;
        lc = b | CHAR_CASE;
        if (b < CHAR_LO || b > CHAR_HI) return -1;
        case (lc)
            CHAR_A_LC: return int'(BASE_A);
            CHAR_C_LC: return int'(BASE_C);
            CHAR_G_LC: return int'(BASE_G);
            CHAR_T_LC: return int'(BASE_T);
            default:   return -1;
        endcase
    endfunction

    function automatic t_record_stats summarise_record();
        logic [63:0]   a, c, g, t, total, gc, pur, pyr;
        logic [63:0]   codons, gcp, tm, ratio;
        t_record_stats r;
        a      = base_cnt[BASE_A];
        c      = base_cnt[BASE_C];
        g      = base_cnt[BASE_G];
        t      = base_cnt[BASE_T];
        total  = a + c + g + t;
        gc     = g + c;
        pur    = a + g;
        pyr    = c + t;
        codons = 64'd0;
        gcp    = 64'd0;
        tm     = 64'd0;
        ratio  = 64'd0;
        if (total != 0) begin
            codons = total / CODON_SIZE;
            if (codons > CODON_MAX) codons = CODON_MAX;
            gcp = (gc * GC_SCALE + total / 2) / total;
            tm  = 2 * (a + t) + 4 * gc;
            if (tm > TM_MAX) tm = TM_MAX;
        end
        if (pyr != 0) begin
            ratio = (pur * RATIO_SCALE + pyr / 2) / pyr;
            if (ratio > RATIO_MAX) ratio = RATIO_MAX;
        end
        r.count_a           = a[OUT_COUNT_W-1:0];
        r.count_c           = c[OUT_COUNT_W-1:0];
        r.count_g           = g[OUT_COUNT_W-1:0];
        r.count_t           = t[OUT_COUNT_W-1:0];
        r.codon_count       = codons[OUT_CODON_W-1:0];
        r.gc_hundredths     = gcp[OUT_GC_W-1:0];
        r.melt_temp         = tm[OUT_TM_W-1:0];
        r.ratio_thousandths = ratio[OUT_RATIO_W-1:0];
        r.ratio_undefined   = (pyr == 0);
        r.no_valid_bases    = (total == 0);
        r.count_saturated   = sat_seen;
        return r;
    endfunction

    task automatic clear_record_state();
        rec_has_chars = 1'b0;
        sat_seen      = 1'b0;
        foreach (base_cnt[k]) base_cnt[k] = 64'd0;
    endtask

    task automatic scan_word(input logic [7:0] b, input logic eof);
        int   lane;
        logic closed;
        closed = 1'b0;
        if (b == CHAR_NEWLINE) begin
            line_start = 1'b1;
            in_header  = 1'b0;
        end else if (line_start && b == CHAR_HEADER) begin
            if (rec_has_chars) begin
                pending_stats.push_back(summarise_record());
                closed = 1'b1;
            end
            clear_record_state();
            in_header  = 1'b1;
            line_start = 1'b0;
        end else begin
            line_start = 1'b0;
            if (!in_header) begin
                lane          = lane_of(b);
                rec_has_chars = 1'b1;
                if (lane >= 0) begin
                    if (base_cnt[lane] < CNT_MAX) base_cnt[lane] = base_cnt[lane] + 1;
                    if (base_cnt[lane] >= CNT_MAX) sat_seen = 1'b1;
                end
            end
        end
        // The final word of a file flushes any open record and rearms the parser.
        if (eof) begin
            if (rec_has_chars && !closed) pending_stats.push_back(summarise_record());
            clear_record_state();
            line_start = 1'b1;
            in_header  = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic logic [7:0] pick_base();
        logic [7:0] b;
        case ($urandom_range(3))
            0:       b = CHAR_A_LC;
            1:       b = CHAR_C_LC;
            2:       b = CHAR_G_LC;
            default: b = CHAR_T_LC;
        endcase
        if ($urandom_range(1) == 1) b = b & ~CHAR_CASE;
        return b;
    endfunction

    // Any byte but a newline, so that line structure stays as planned.
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == CHAR_NEWLINE) ? CHAR_CR : b;
    endfunction

    task automatic add_word(input logic [7:0] b);
        t_file_word w;
        w.data = b;
        w.eof  = 1'b0;
        file_buf.push_back(w);
    endtask

    task automatic add_seq_line(input int len);
        for (int i = 0; i < len; i++)
            add_word(($urandom_range(7) == 0) ? pick_noise() : pick_base());
        if ($urandom_range(5) == 0) add_word(CHAR_CR);
        add_word(CHAR_NEWLINE);
    endtask

    task automatic end_file();
        if (file_buf.size() == 0) add_word(CHAR_NEWLINE);
        file_buf[file_buf.size()-1].eof = 1'b1;
        foreach (file_buf[k]) text_q.push_back(file_buf[k]);
        words_queued += file_buf.size();
        files_queued++;
        file_buf.delete();
    endtask

    task automatic queue_random_file();
        int n_rec;
        if ($urandom_range(11) == 0) begin
            // Broken file: raw bytes with newlines and '>' anywhere.
            repeat ($urandom_range(20, 1)) begin
                case ($urandom_range(5))
                    0:       add_word(CHAR_NEWLINE);
                    1:       add_word(CHAR_HEADER);
                    default: add_word(8'($urandom_range(255)));
                endcase
            end
        end else begin
            if ($urandom_range(7) == 0) add_seq_line($urandom_range(8, 1));
            n_rec = $urandom_range(4, 1);
            repeat (n_rec) begin
                add_word(CHAR_HEADER);
                repeat ($urandom_range(6)) add_word(pick_noise());
                add_word(CHAR_NEWLINE);
                repeat ($urandom_range(3)) add_seq_line($urandom_range(12));
            end
            case ($urandom_range(3))
                0: if (file_buf.size() > 1) void'(file_buf.pop_back());
                1: add_word(CHAR_HEADER);
                default: ;
            endcase
        end
        end_file();
    endtask

    task automatic queue_directed();
        // Sequence ahead of any header, both letter cases.
        add_word(CHAR_A_LC & ~CHAR_CASE);
        add_word(CHAR_C_LC);
        add_word(CHAR_G_LC & ~CHAR_CASE);
        add_word(CHAR_T_LC);
        add_word(CHAR_NEWLINE);
        add_word(CHAR_HEADER);
        add_word(8'hFF);
        add_word(CHAR_NEWLINE);
        add_word(CHAR_NEWLINE);
        // A record of bytes with no base in it, '>' in mid-line among them.
        add_word(8'h00);
        add_word(CHAR_CR);
        add_word(CHAR_HEADER);
        add_word(8'hFF);
        add_word(CHAR_NEWLINE);
        // Header on the final word closes that record and opens an empty one.
        add_word(CHAR_HEADER);
        end_file();
        // Purines only, so the ratio is undefined; then a pure GC record.
        add_word(CHAR_A_LC);
        add_word(CHAR_G_LC & ~CHAR_CASE);
        add_word(CHAR_NEWLINE);
        add_word(CHAR_HEADER);
        add_word(CHAR_NEWLINE);
        add_word(CHAR_C_LC & ~CHAR_CASE);
        add_word(CHAR_C_LC);
        add_word(CHAR_G_LC);
        end_file();
    endtask

    task automatic wait_drained();
        while (words_taken != words_queued || pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        word_fire = i_valid && !o_stall;
        if (word_fire) begin
            scan_word(i_data_byte, i_end_of_file);
            void'(text_q.pop_front());
            words_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || word_fire)) begin
            if (text_q.size() != 0 && (calm_left != 0 || $urandom_range(99) >= send_idle)) begin
                i_valid       <= 1'b1;
                i_data_byte   <= text_q[0].data;
                i_end_of_file <= text_q[0].eof;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0d, predicted %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(negedge i_clk) begin
        i_stall <= (calm_left == 0) && ($urandom_range(99) < recv_idle);
    end

    always @(posedge i_clk) begin
        t_record_stats want;
        if (o_valid && !i_stall) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("unpredicted result word", 64'd0, 64'd0);
            end else begin
                want = pending_stats.pop_front();
                compare_field("count_a", o_count_a, want.count_a);
                compare_field("count_c", o_count_c, want.count_c);
                compare_field("count_g", o_count_g, want.count_g);
                compare_field("count_t", o_count_t, want.count_t);
                compare_field("codon_count", o_codon_count, want.codon_count);
                compare_field("gc_hundredths_percent", o_gc_hundredths_percent,
                              want.gc_hundredths);
                compare_field("melt_temp", o_melt_temp, want.melt_temp);
                compare_field("ratio_thousandths", o_ratio_thousandths,
                              want.ratio_thousandths);
                compare_field("ratio_undefined", o_ratio_undefined, want.ratio_undefined);
                compare_field("no_valid_bases", o_no_valid_bases, want.no_valid_bases);
                compare_field("count_saturated", o_count_saturated, want.count_saturated);
                records_checked++;
            end
        end
    end

    // Cycle limit, and short stretches in which neither side idles.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL fasta_record_base_statistics");
            $finish;
        end
        if (calm_left != 0)
            calm_left--;
        else if ($urandom_range(99) == 0)
            calm_left = $urandom_range(40, 10);
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 37;
        recv_idle = 81;
        queue_directed();
        target = words_queued + 700;
        while (words_queued < target) queue_random_file();
        wait_drained();

        send_idle = 81;
        recv_idle = 37;
        target = words_queued + 650;
        while (words_queued < target) queue_random_file();
        wait_drained();

        send_idle = 0;
        recv_idle = 0;
        target = words_queued + 650;
        while (words_queued < target) queue_random_file();
        wait_drained();

        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("Streamed %0d words in %0d files; %0d record results checked, %0d mismatches.",
                 words_taken, files_queued, records_checked, fail_count);
        if (fail_count == 0)
            $display("PASS fasta_record_base_statistics");
        else
            $display("FAIL fasta_record_base_statistics");
        $finish;
    end

endmodule

@@ fasta_record_base_statistics.f @@
rtl/core/fbs_pkg.sv
rtl/core/fbs_divider.sv
rtl/core/fbs_ctrl.sv
rtl/core/fbs_datapath.sv
rtl/core/fasta_record_base_statistics.sv
bench/testbench.sv
